### hdl/shirr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shirr_pkg: shared types and constants of the SH ambient irradiance unit
// Word layouts, fixed-point constants and register indexes.
// ----------------------------------------------------------------------------
package shirr_pkg;

    localparam int DIR_WIDTH   = 16;    // direction component width
    localparam int LIGHT_WIDTH = 20;    // Q7.12 output channel

    // Normalization datapath
    localparam int NORM_BITS     = 15;               // prescaled magnitude
    localparam int SQ_BITS       = 2 * NORM_BITS;    // squared magnitude
    localparam int N2_BITS       = SQ_BITS + 2;      // sum of three squares
    localparam int QUO_BITS      = 33;               // 2^60 / n2 <= 2^32
    localparam int DIV_STEPS     = QUO_BITS;         // one quotient bit per stage
    localparam int ROOT_W        = 34;
    localparam int ROOT_STEPS    = 17;               // one result bit per stage
    localparam int ROOT_OUT_BITS = 17;
    localparam int UNIT_BITS     = 17;               // unit component magnitude

    // Remainder after the dividend bits above the quotient range: 2^60 >> 33
    localparam logic [N2_BITS-1:0] DIV_REM_INIT = N2_BITS'(1) << 27;

    // SH constants, Q0.16, carried as 17-bit signed
    localparam int KC_W = 17;
    localparam logic signed [KC_W-1:0] KC0_S = 17'sd18487;
    localparam logic signed [KC_W-1:0] KC1_S = 17'sd32021;
    localparam logic signed [KC_W-1:0] KC6_S = 17'sd20670;
    localparam logic signed [KC_W-1:0] KC8_S = 17'sd35801;

    localparam int B_W = 20;    // basis terms, Q.16 signed

    // Register indexes
    localparam logic [1:0] REG_SKY     = 2'd0;
    localparam logic [1:0] REG_EQUATOR = 2'd1;
    localparam logic [1:0] REG_GROUND  = 2'd2;

    typedef struct packed {
        logic signed [DIR_WIDTH-1:0] dir_x;
        logic signed [DIR_WIDTH-1:0] dir_y;
        logic signed [DIR_WIDTH-1:0] dir_z;
    } dir_word_t;

    typedef struct packed {
        logic signed [LIGHT_WIDTH-1:0] light_red;
        logic signed [LIGHT_WIDTH-1:0] light_green;
        logic signed [LIGHT_WIDTH-1:0] light_blue;
        logic                          zero_direction;
    } light_word_t;

endpackage
`default_nettype wire

### hdl/sh_ambient_irradiance_eval_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sh_ambient_irradiance_eval_unit: L2 spherical-harmonic ambient light
// Evaluates sky/equator/ground gradient ambient light for one direction word
// per clock.
// ----------------------------------------------------------------------------
// Usage: a direction word is taken on every clock where start is high (busy
// is never raised), so one word per cycle may be streamed in. The result word
// appears on light with done high for exactly one cycle, in input order; the
// receiver cannot stall and must capture it in that cycle. The pipeline has
// 5 prescale/sum stages, a 33-stage bit-per-stage divider for 2^60/n2, a
// 17-stage bit-per-stage square root, and 9 stages of basis evaluation, dot
// product, rounding and saturation. Color registers must be written through
// the cfg channel (always ready) only while no word is in flight; the block
// itself does not enforce this. The derived SH coefficients are registered
// in the cs and then in the c coefficient registers after a write.
//
// Notes:
//  - Coefficients c0, c1, c6 and c8 per channel come from the three colors;
//    all other L2 terms are zero for this gradient.
//  - The direction is prescaled so its largest component has 15 bits, then
//    normalized by isqrt(2^60 / n2).
//  - A zero direction gives zero light and sets zero_direction.
//  - Writes to an unused register index are dropped.
// ----------------------------------------------------------------------------
module sh_ambient_irradiance_eval_unit
    import shirr_pkg::*;
#(
    parameter int COLOR_WIDTH = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // direction in
    input  wire logic                       start,
    output logic                            busy,
    input  wire dir_word_t                  dir,
    // light out
    output logic                            done,
    output light_word_t                     light,
    // configuration
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [3*COLOR_WIDTH-1:0]   cfg_data
);

    localparam int MAG_W     = DIR_WIDTH;
    localparam int BL_W      = $clog2(DIR_WIDTH + 1);
    localparam int SHF_W     = DIR_WIDTH + NORM_BITS;
    localparam int CFG_W     = 3 * COLOR_WIDTH;
    localparam int CS_W      = COLOR_WIDTH + 4;
    localparam int CS_PROD_W = CS_W + KC_W;
    localparam int CC_W      = COLOR_WIDTH + 8;
    localparam int PR_W      = CC_W + B_W;
    localparam int SUM_W     = PR_W + 2;
    localparam int UPROD_W   = NORM_BITS + ROOT_OUT_BITS;
    localparam int USQ_W     = 2 * (UNIT_BITS + 1);
    localparam int B1P_W     = KC_W + UNIT_BITS + 1;
    localparam int P_W       = 34;
    localparam int M_W       = KC_W + P_W;
    localparam int TAIL      = 8;

    localparam logic signed [CS_PROD_W-1:0] RND12 = CS_PROD_W'(1) << 11;
    localparam logic signed [B1P_W-1:0]     RND15 = B1P_W'(1) << 14;
    localparam logic signed [M_W-1:0]       RND30 = M_W'(1) << 29;
    localparam logic signed [SUM_W-1:0]     RND20 = SUM_W'(1) << 19;
    localparam logic signed [SUM_W-1:0]     OUT_MAX_S = SUM_W'(524287);
    localparam logic signed [SUM_W-1:0]     OUT_MIN_S = -SUM_W'(524288);

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Color registers and derived coefficients
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] sky_reg, equator_reg, ground_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sky_reg     <= '0;
            equator_reg <= '0;
            ground_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SKY:     sky_reg     <= cfg_data;
                REG_EQUATOR: equator_reg <= cfg_data;
                REG_GROUND:  ground_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    logic signed [CS_W-1:0] cs0_next [3], cs1_next [3], cs6_next [3];
    logic signed [CS_W-1:0] cs0_reg  [3], cs1_reg  [3], cs6_reg  [3];
    logic signed [CC_W-1:0] c0_next [3], c1_next [3], c6_next [3], c8_next [3];
    logic signed [CC_W-1:0] c0_reg  [3], c1_reg  [3], c6_reg  [3], c8_reg  [3];

    always_comb
    begin
        logic signed [CS_W-1:0]      ss, es, gs;
        logic signed [CS_PROD_W-1:0] p0, p1, p6, p8;
        for (int ch = 0; ch < 3; ch++)
        begin
            ss = $signed(CS_W'(sky_reg[ch*COLOR_WIDTH +: COLOR_WIDTH]));
            es = $signed(CS_W'(equator_reg[ch*COLOR_WIDTH +: COLOR_WIDTH]));
            gs = $signed(CS_W'(ground_reg[ch*COLOR_WIDTH +: COLOR_WIDTH]));
            cs0_next[ch] = ss + gs + (es <<< 2);
            cs1_next[ch] = ss - gs;
            cs6_next[ch] = (es <<< 1) - ss - gs;

            p0 = KC0_S * cs0_reg[ch];
            p1 = KC1_S * cs1_reg[ch];
            p6 = KC6_S * cs6_reg[ch];
            p8 = KC8_S * cs6_reg[ch];
            c0_next[ch] = CC_W'((p0 + RND12) >>> 12);
            c1_next[ch] = CC_W'((p1 + RND12) >>> 12);
            c6_next[ch] = CC_W'((p6 + RND12) >>> 12);
            c8_next[ch] = CC_W'((p8 + RND12) >>> 12);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                cs0_reg[ch] <= '0;
                cs1_reg[ch] <= '0;
                cs6_reg[ch] <= '0;
                c0_reg[ch]  <= '0;
                c1_reg[ch]  <= '0;
                c6_reg[ch]  <= '0;
                c8_reg[ch]  <= '0;
            end
        end
        else
        begin
            cs0_reg <= cs0_next;
            cs1_reg <= cs1_next;
            cs6_reg <= cs6_next;
            c0_reg  <= c0_next;
            c1_reg  <= c1_next;
            c6_reg  <= c6_next;
            c8_reg  <= c8_next;
        end
    end

    // ------------------------------------------------------------------
    // Front: magnitude, bit length, prescale, squares, n2
    // ------------------------------------------------------------------
    logic [4:0] fe_valid_reg;   // stages A..E

    logic [MAG_W-1:0]     comp [3];
    logic [MAG_W-1:0]     a_mag_next [3], a_mag_reg [3];
    logic [2:0]           a_neg_next, a_neg_reg;
    logic [MAG_W-1:0]     b_max;
    logic [BL_W-1:0]      b_bl_next, b_bl_reg;
    logic                 b_zero_next, b_zero_reg;
    logic [MAG_W-1:0]     b_mag_reg [3];
    logic [2:0]           b_neg_reg;
    logic [SHF_W-1:0]     c_shf [3];
    logic [NORM_BITS-1:0] c_mag_next [3], c_mag_reg [3];
    logic [2:0]           c_neg_reg;
    logic                 c_zero_reg;
    logic [SQ_BITS-1:0]   d_sq_next [3], d_sq_reg [3];
    logic [NORM_BITS-1:0] d_mag_reg [3];
    logic [2:0]           d_neg_reg;
    logic                 d_zero_reg;
    logic [N2_BITS-1:0]   e_n2_next, e_n2_reg;
    logic [NORM_BITS-1:0] e_mag_reg [3];
    logic [2:0]           e_neg_reg;
    logic                 e_zero_reg;

    assign comp[0] = dir.dir_x;
    assign comp[1] = dir.dir_y;
    assign comp[2] = dir.dir_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_neg_next[i] = comp[i][MAG_W-1];
            a_mag_next[i] = comp[i][MAG_W-1] ? (~comp[i] + 1'b1) : comp[i];
        end

        b_max = a_mag_reg[0];
        if (a_mag_reg[1] > b_max)
            b_max = a_mag_reg[1];
        if (a_mag_reg[2] > b_max)
            b_max = a_mag_reg[2];
        b_bl_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (b_max[i])
                b_bl_next = BL_W'(i + 1);
        end
        b_zero_next = (b_max == '0);

        // (mag << 15) >> bl covers both shift directions
        for (int i = 0; i < 3; i++)
        begin
            c_shf[i]      = {b_mag_reg[i], {NORM_BITS{1'b0}}} >> b_bl_reg;
            c_mag_next[i] = c_shf[i][NORM_BITS-1:0];
            d_sq_next[i]  = c_mag_reg[i] * c_mag_reg[i];
        end

        e_n2_next = N2_BITS'(d_sq_reg[0]) + N2_BITS'(d_sq_reg[1])
                  + N2_BITS'(d_sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fe_valid_reg <= '0;
        else
            fe_valid_reg <= {fe_valid_reg[3:0], start && !busy};
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg  <= a_mag_next;
        a_neg_reg  <= a_neg_next;
        b_mag_reg  <= a_mag_reg;
        b_neg_reg  <= a_neg_reg;
        b_bl_reg   <= b_bl_next;
        b_zero_reg <= b_zero_next;
        c_mag_reg  <= c_mag_next;
        c_neg_reg  <= b_neg_reg;
        c_zero_reg <= b_zero_reg;
        d_sq_reg   <= d_sq_next;
        d_mag_reg  <= c_mag_reg;
        d_neg_reg  <= c_neg_reg;
        d_zero_reg <= c_zero_reg;
        e_n2_reg   <= e_n2_next;
        e_mag_reg  <= d_mag_reg;
        e_neg_reg  <= d_neg_reg;
        e_zero_reg <= d_zero_reg;
    end

    // ------------------------------------------------------------------
    // Divider: q = floor(2^60 / n2), one quotient bit per stage
    // ------------------------------------------------------------------
    logic [DIV_STEPS-1:0] dv_valid_reg;
    logic [DIV_STEPS-1:0] dv_zero_reg;
    logic [N2_BITS-1:0]   dv_rem_in [DIV_STEPS], dv_rem_next [DIV_STEPS];
    logic [N2_BITS-1:0]   dv_rem_reg [DIV_STEPS];
    logic [N2_BITS-1:0]   dv_n2_in [DIV_STEPS], dv_n2_reg [DIV_STEPS];
    logic [QUO_BITS-1:0]  dv_quo_in [DIV_STEPS], dv_quo_next [DIV_STEPS];
    logic [QUO_BITS-1:0]  dv_quo_reg [DIV_STEPS];
    logic [N2_BITS:0]     dv_sh [DIV_STEPS];
    logic                 dv_ge [DIV_STEPS];
    logic [NORM_BITS-1:0] dv_mag_reg [DIV_STEPS][3];
    logic [2:0]           dv_neg_reg [DIV_STEPS];

    always_comb
    begin
        dv_rem_in[0] = DIV_REM_INIT;
        dv_quo_in[0] = '0;
        dv_n2_in[0]  = e_n2_reg;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            dv_rem_in[k] = dv_rem_reg[k-1];
            dv_quo_in[k] = dv_quo_reg[k-1];
            dv_n2_in[k]  = dv_n2_reg[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            dv_sh[k] = {dv_rem_in[k], 1'b0};
            dv_ge[k] = (dv_sh[k] >= {1'b0, dv_n2_in[k]});
            dv_rem_next[k] = dv_ge[k] ? N2_BITS'(dv_sh[k] - {1'b0, dv_n2_in[k]})
                                      : N2_BITS'(dv_sh[k]);
            dv_quo_next[k] = {dv_quo_in[k][QUO_BITS-2:0], dv_ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg <= '0;
        else
            dv_valid_reg <= {dv_valid_reg[DIV_STEPS-2:0], fe_valid_reg[4]};
    end

    always_ff @(posedge clk)
    begin
        dv_rem_reg    <= dv_rem_next;
        dv_quo_reg    <= dv_quo_next;
        dv_n2_reg     <= dv_n2_in;
        dv_zero_reg   <= {dv_zero_reg[DIV_STEPS-2:0], e_zero_reg};
        dv_mag_reg[0] <= e_mag_reg;
        dv_neg_reg[0] <= e_neg_reg;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            dv_mag_reg[k] <= dv_mag_reg[k-1];
            dv_neg_reg[k] <= dv_neg_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Square root: r = isqrt(q), one result bit per stage
    // ------------------------------------------------------------------
    logic [ROOT_STEPS-1:0] sq_valid_reg;
    logic [ROOT_STEPS-1:0] sq_zero_reg;
    logic [ROOT_W-1:0]     sq_x_in [ROOT_STEPS], sq_x_next [ROOT_STEPS];
    logic [ROOT_W-1:0]     sq_x_reg [ROOT_STEPS];
    logic [ROOT_W-1:0]     sq_res_in [ROOT_STEPS], sq_res_next [ROOT_STEPS];
    logic [ROOT_W-1:0]     sq_res_reg [ROOT_STEPS];
    logic [ROOT_W-1:0]     sq_bit [ROOT_STEPS], sq_trial [ROOT_STEPS];
    logic                  sq_ge [ROOT_STEPS];
    logic [NORM_BITS-1:0]  sq_mag_reg [ROOT_STEPS][3];
    logic [2:0]            sq_neg_reg [ROOT_STEPS];

    always_comb
    begin
        sq_x_in[0]   = ROOT_W'(dv_quo_reg[DIV_STEPS-1]);
        sq_res_in[0] = '0;
        for (int k = 1; k < ROOT_STEPS; k++)
        begin
            sq_x_in[k]   = sq_x_reg[k-1];
            sq_res_in[k] = sq_res_reg[k-1];
        end
        for (int k = 0; k < ROOT_STEPS; k++)
        begin
            sq_bit[k]      = ROOT_W'(1) << (2 * (ROOT_STEPS - 1 - k));
            sq_trial[k]    = sq_res_in[k] + sq_bit[k];
            sq_ge[k]       = (sq_x_in[k] >= sq_trial[k]);
            sq_x_next[k]   = sq_ge[k] ? (sq_x_in[k] - sq_trial[k]) : sq_x_in[k];
            sq_res_next[k] = sq_ge[k] ? ((sq_res_in[k] >> 1) + sq_bit[k])
                                      : (sq_res_in[k] >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= '0;
        else
            sq_valid_reg <= {sq_valid_reg[ROOT_STEPS-2:0], dv_valid_reg[DIV_STEPS-1]};
    end

    always_ff @(posedge clk)
    begin
        sq_x_reg      <= sq_x_next;
        sq_res_reg    <= sq_res_next;
        sq_zero_reg   <= {sq_zero_reg[ROOT_STEPS-2:0], dv_zero_reg[DIV_STEPS-1]};
        sq_mag_reg[0] <= dv_mag_reg[DIV_STEPS-1];
        sq_neg_reg[0] <= dv_neg_reg[DIV_STEPS-1];
        for (int k = 1; k < ROOT_STEPS; k++)
        begin
            sq_mag_reg[k] <= sq_mag_reg[k-1];
            sq_neg_reg[k] <= sq_neg_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Tail: unit vector, basis, dot product, round, saturate
    //   U  V  W  X  Y  Z  S1 S2 -> output register
    // ------------------------------------------------------------------
    logic [TAIL-1:0] tl_valid_reg, tl_zero_reg;

    logic [ROOT_OUT_BITS-1:0]     root;
    logic [UPROD_W-1:0]           u_prod [3];
    logic [UNIT_BITS-1:0]         u_mag [3];
    logic signed [UNIT_BITS:0]    u_next [3], u_reg [3];
    logic signed [USQ_W-1:0]      v_sq_next [3], v_sq_reg [3];
    logic signed [B1P_W-1:0]      v_b1p_next, v_b1p_reg;
    logic signed [P_W-1:0]        w_p6_next, w_p6_reg, w_p8_next, w_p8_reg;
    logic signed [B_W-1:0]        w_b1_next, w_b1_reg;
    logic signed [M_W-1:0]        x_m6_next, x_m6_reg, x_m8_next, x_m8_reg;
    logic signed [B_W-1:0]        x_b1_reg;
    logic signed [B_W-1:0]        y_b6_next, y_b6_reg, y_b8_next, y_b8_reg;
    logic signed [B_W-1:0]        y_b1_reg;
    logic signed [PR_W-1:0]       z_t0_next [3], z_t1_next [3], z_t6_next [3], z_t8_next [3];
    logic signed [PR_W-1:0]       z_t0_reg [3], z_t1_reg [3], z_t6_reg [3], z_t8_reg [3];
    logic signed [SUM_W-1:0]      s1_a_next [3], s1_a_reg [3], s1_b_next [3], s1_b_reg [3];
    logic signed [SUM_W-1:0]      s2_tot_next [3], s2_tot_reg [3];
    logic signed [SUM_W-1:0]      rounded [3];
    logic signed [LIGHT_WIDTH-1:0] chan_out [3];
    light_word_t                  light_next, light_reg;
    logic                         done_reg;

    assign root = sq_res_reg[ROOT_STEPS-1][ROOT_OUT_BITS-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_prod[i] = sq_mag_reg[ROOT_STEPS-1][i] * root;
            u_mag[i]  = u_prod[i][UPROD_W-1:NORM_BITS];
            u_next[i] = sq_neg_reg[ROOT_STEPS-1][i] ? -$signed({1'b0, u_mag[i]})
                                                    :  $signed({1'b0, u_mag[i]});
            v_sq_next[i] = u_reg[i] * u_reg[i];
        end
        v_b1p_next = KC1_S * u_reg[1];

        w_p6_next = P_W'((v_sq_reg[2] <<< 1) - v_sq_reg[0] - v_sq_reg[1]);
        w_p8_next = P_W'(v_sq_reg[0] - v_sq_reg[1]);
        w_b1_next = B_W'((v_b1p_reg + RND15) >>> 15);

        x_m6_next = KC6_S * w_p6_reg;
        x_m8_next = KC8_S * w_p8_reg;

        y_b6_next = B_W'((x_m6_reg + RND30) >>> 30);
        y_b8_next = B_W'((x_m8_reg + RND30) >>> 30);

        for (int ch = 0; ch < 3; ch++)
        begin
            z_t0_next[ch]   = KC0_S * c0_reg[ch];
            z_t1_next[ch]   = y_b1_reg * c1_reg[ch];
            z_t6_next[ch]   = y_b6_reg * c6_reg[ch];
            z_t8_next[ch]   = y_b8_reg * c8_reg[ch];
            s1_a_next[ch]   = z_t0_reg[ch] + z_t1_reg[ch];
            s1_b_next[ch]   = z_t6_reg[ch] + z_t8_reg[ch];
            s2_tot_next[ch] = s1_a_reg[ch] + s1_b_reg[ch];

            rounded[ch] = (s2_tot_reg[ch] + RND20) >>> 20;
            if (rounded[ch] > OUT_MAX_S)
                chan_out[ch] = LIGHT_WIDTH'(OUT_MAX_S);
            else if (rounded[ch] < OUT_MIN_S)
                chan_out[ch] = LIGHT_WIDTH'(OUT_MIN_S);
            else
                chan_out[ch] = LIGHT_WIDTH'(rounded[ch]);
        end

        if (tl_zero_reg[TAIL-1])
        begin
            light_next.light_red      = '0;
            light_next.light_green    = '0;
            light_next.light_blue     = '0;
            light_next.zero_direction = 1'b1;
        end
        else
        begin
            light_next.light_red      = chan_out[0];
            light_next.light_green    = chan_out[1];
            light_next.light_blue     = chan_out[2];
            light_next.zero_direction = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tl_valid_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            tl_valid_reg <= {tl_valid_reg[TAIL-2:0], sq_valid_reg[ROOT_STEPS-1]};
            done_reg     <= tl_valid_reg[TAIL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        tl_zero_reg <= {tl_zero_reg[TAIL-2:0], sq_zero_reg[ROOT_STEPS-1]};
        u_reg       <= u_next;
        v_sq_reg    <= v_sq_next;
        v_b1p_reg   <= v_b1p_next;
        w_p6_reg    <= w_p6_next;
        w_p8_reg    <= w_p8_next;
        w_b1_reg    <= w_b1_next;
        x_m6_reg    <= x_m6_next;
        x_m8_reg    <= x_m8_next;
        x_b1_reg    <= w_b1_reg;
        y_b6_reg    <= y_b6_next;
        y_b8_reg    <= y_b8_next;
        y_b1_reg    <= x_b1_reg;
        z_t0_reg    <= z_t0_next;
        z_t1_reg    <= z_t1_next;
        z_t6_reg    <= z_t6_next;
        z_t8_reg    <= z_t8_next;
        s1_a_reg    <= s1_a_next;
        s1_b_reg    <= s1_b_next;
        s2_tot_reg  <= s2_tot_next;
        light_reg   <= light_next;
    end

    assign done  = done_reg;
    assign light = light_reg;

endmodule
`default_nettype wire
